>>> design/sktrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sktrs_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam logic [2:0] KEY_MIN     = 3'd1;
	localparam logic [2:0] KEY_MAX     = 3'd6;
	localparam logic       FUNC_INSERT = 1'b0;

	typedef struct packed {
		logic [2:0]  key;
		logic [6:0]  model;
		logic [7:0]  color;
		logic [1:0]  gender;
		logic [2:0]  size;
		logic [23:0] price;
	} rec_t;

	typedef struct packed {
		logic        func;
		logic [2:0]  key;
		logic [7:0]  color;
		logic [1:0]  gender;
		logic [2:0]  size;
		logic [23:0] price;
		logic        by_price;
		logic        desc;
		logic        filt;
	} req_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_BAD_TYPE  = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_RECORD    = 3'd3,
		ST_NONE_KEPT = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_SET_BAD,
		CMD_SET_FULL,
		CMD_SET_NOTFOUND,
		CMD_SET_NONE,
		CMD_INS_INIT,
		CMD_SRCH_INIT,
		CMD_ISCAN_RD,
		CMD_ISCAN_CHK,
		CMD_ISHIFT_RD,
		CMD_ISHIFT_WR,
		CMD_IWRITE,
		CMD_BIN_RD,
		CMD_BIN_CHK,
		CMD_TURN,
		CMD_RD_DN,
		CMD_RD_UP,
		CMD_TAKE,
		CMD_FREAD,
		CMD_FPLACE,
		CMD_FSHIFT,
		CMD_EMIT_INIT,
		CMD_EMIT_RD,
		CMD_EMIT_PUSH,
		CMD_RESP_PUSH
	} cmd_t;

	typedef struct packed {
		logic key_bad;
		logic is_ins;
		logic full;
		logic idx_end;
		logic pos_hit;
		logic bin_empty;
		logic t_eq;
		logic dn;
		logic j_zero;
		logic j_last;
		logic skip;
		logic k_zero;
		logic by_price;
		logic shift_ok;
		logic nf_zero;
		logic emit_last;
		logic out_free;
	} flag_t;

endpackage
`default_nettype wire

>>> design/sktrs_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sktrs_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [2:0]  type_code;
	logic [7:0]  color_code;
	logic [1:0]  gender_code;
	logic [2:0]  size_code;
	logic [23:0] price_cents;
	logic        sort_by_price;
	logic        descending;
	logic        filter_gender;

	modport source (output valid, func, type_code, color_code, gender_code, size_code,
		price_cents, sort_by_price, descending, filter_gender, input ready);
	modport sink (input valid, func, type_code, color_code, gender_code, size_code,
		price_cents, sort_by_price, descending, filter_gender, output ready);
endinterface
`default_nettype wire

>>> design/sktrs_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sktrs_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [2:0]  rec_type;
	logic [6:0]  rec_model;
	logic [7:0]  rec_color;
	logic [1:0]  rec_gender;
	logic [2:0]  rec_size;
	logic [23:0] rec_price;
	logic        last;

	modport source (output valid, status, rec_type, rec_model, rec_color, rec_gender,
		rec_size, rec_price, last, input ready);
	modport sink (input valid, status, rec_type, rec_model, rec_color, rec_gender,
		rec_size, rec_price, last, output ready);
endinterface
`default_nettype wire

>>> design/sorted_key_table_range_search.sv
`timescale 1ns / 1ps
`default_nettype none
// Sorted key table with range search. Holds up to TABLE_DEPTH records kept in
// type order (type codes 1..6) in a single-port-read RAM. An insert request scans
// the table once to find the next model number and the insertion point, shifts
// the tail up one entry and writes the new record. A search request runs a binary
// search, gathers the matching run outward from the hit, drops records that fail
// the gender filter, and places each kept record into a second RAM, by insertion
// on price when price sorting is asked for and in gather order otherwise, then
// streams the list out. One request is worked at a time; a new request is taken
// while the last result still waits on the output register. No clearing pass
// follows reset: only entries below the record count are ever read.
module sorted_key_table_range_search #(
	parameter int TABLE_DEPTH = sktrs_pkg::TABLE_DEPTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	sktrs_in_if.sink  req,
	sktrs_out_if.source rsp
);
	import sktrs_pkg::*;

	req_t  req_s;
	cmd_t  cmd;
	flag_t flg;

	// Pack the request fields for the datapath
	assign req_s = '{func: req.func, key: req.type_code, color: req.color_code,
		gender: req.gender_code, size: req.size_code, price: req.price_cents,
		by_price: req.sort_by_price, desc: req.descending, filt: req.filter_gender};

	sktrs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.flg(flg),
		.cmd(cmd)
	);

	sktrs_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.req(req_s),
		.flg(flg),
		.rsp(rsp)
	);
endmodule
`default_nettype wire

>>> design/sktrs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sktrs_ram #(
	parameter int W = 8,
	parameter int D = 64,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

>>> design/sktrs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sktrs_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire sktrs_pkg::flag_t flg,
	output sktrs_pkg::cmd_t      cmd
);
	import sktrs_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_DEC    = 10'b0000000010,
		S_ISCAN  = 10'b0000000100,
		S_ISHIFT = 10'b0000001000,
		S_IWRITE = 10'b0000010000,
		S_BIN    = 10'b0000100000,
		S_NEXT   = 10'b0001000000,
		S_INS    = 10'b0010000000,
		S_EMIT   = 10'b0100000000,
		S_RESP   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   ph_q, ph_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		cmd     = CMD_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd     = CMD_LOAD;
					state_d = S_DEC;
					ph_d    = 1'b0;
				end
			end
			S_DEC: begin
				if (flg.key_bad) begin
					cmd     = CMD_SET_BAD;
					state_d = S_RESP;
				end else if (flg.is_ins && flg.full) begin
					cmd     = CMD_SET_FULL;
					state_d = S_RESP;
				end else if (flg.is_ins) begin
					cmd     = CMD_INS_INIT;
					state_d = S_ISCAN;
				end else begin
					cmd     = CMD_SRCH_INIT;
					state_d = S_BIN;
				end
			end
			S_ISCAN: begin
				if (ph_q) begin
					cmd  = CMD_ISCAN_CHK;
					ph_d = 1'b0;
				end else if (flg.idx_end) begin
					state_d = S_ISHIFT;
				end else begin
					cmd  = CMD_ISCAN_RD;
					ph_d = 1'b1;
				end
			end
			S_ISHIFT: begin
				if (ph_q) begin
					cmd  = CMD_ISHIFT_WR;
					ph_d = 1'b0;
				end else if (flg.pos_hit) begin
					state_d = S_IWRITE;
				end else begin
					cmd  = CMD_ISHIFT_RD;
					ph_d = 1'b1;
				end
			end
			S_IWRITE: begin
				cmd     = CMD_IWRITE;
				state_d = S_RESP;
			end
			S_BIN: begin
				if (ph_q) begin
					cmd  = CMD_BIN_CHK;
					ph_d = 1'b0;
					if (flg.t_eq) begin
						state_d = S_INS;
					end
				end else if (flg.bin_empty) begin
					cmd     = CMD_SET_NOTFOUND;
					state_d = S_RESP;
				end else begin
					cmd  = CMD_BIN_RD;
					ph_d = 1'b1;
				end
			end
			S_NEXT: begin
				if (ph_q) begin
					ph_d = 1'b0;
					if (flg.t_eq) begin
						cmd     = CMD_TAKE;
						state_d = S_INS;
					end else if (flg.dn) begin
						cmd = CMD_TURN;
					end else if (flg.nf_zero) begin
						cmd     = CMD_SET_NONE;
						state_d = S_RESP;
					end else begin
						cmd     = CMD_EMIT_INIT;
						state_d = S_EMIT;
					end
				end else if (flg.dn && flg.j_zero) begin
					cmd = CMD_TURN;
				end else if (flg.dn) begin
					cmd  = CMD_RD_DN;
					ph_d = 1'b1;
				end else if (!flg.j_last) begin
					cmd  = CMD_RD_UP;
					ph_d = 1'b1;
				end else if (flg.nf_zero) begin
					cmd     = CMD_SET_NONE;
					state_d = S_RESP;
				end else begin
					cmd     = CMD_EMIT_INIT;
					state_d = S_EMIT;
				end
			end
			S_INS: begin
				if (ph_q) begin
					ph_d = 1'b0;
					if (flg.shift_ok) begin
						cmd = CMD_FSHIFT;
					end else begin
						cmd     = CMD_FPLACE;
						state_d = S_NEXT;
					end
				end else if (flg.skip) begin
					state_d = S_NEXT;
				end else if (flg.k_zero || !flg.by_price) begin
					cmd     = CMD_FPLACE;
					state_d = S_NEXT;
				end else begin
					cmd  = CMD_FREAD;
					ph_d = 1'b1;
				end
			end
			S_EMIT: begin
				if (!ph_q) begin
					cmd  = CMD_EMIT_RD;
					ph_d = 1'b1;
				end else if (flg.out_free) begin
					cmd  = CMD_EMIT_PUSH;
					ph_d = 1'b0;
					if (flg.emit_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_RESP: begin
				if (flg.out_free) begin
					cmd     = CMD_RESP_PUSH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
				ph_d    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
		end
	end
endmodule
`default_nettype wire

>>> design/sktrs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module sktrs_dp #(
	parameter int TABLE_DEPTH = sktrs_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sktrs_pkg::cmd_t  cmd,
	input  wire sktrs_pkg::req_t  req,
	output sktrs_pkg::flag_t      flg,
	sktrs_out_if.source           rsp
);
	import sktrs_pkg::*;

	localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW    = $clog2(TABLE_DEPTH + 1);
	localparam int REC_W = $bits(rec_t);

	req_t          r_q;
	logic [CW-1:0] cnt_q, idx_q, pos_q, lo_q, hx_q, mid_q, j_q, k_q, nf_q, ei_q;
	logic          posf_q, dn_q;
	logic [6:0]    model_q;
	rec_t          cand_q;
	status_t       stat_q;
	logic          ov_q, olast_q;
	rec_t          o_q;
	status_t       ost_q;

	logic          t_we, t_re, f_we, f_re;
	logic [AW-1:0] t_waddr, t_raddr, f_waddr, f_raddr;
	rec_t          t_wdata, f_wdata, t_rd, f_rd, new_rec;
	logic [CW-1:0] mid_c;
	logic          out_free;

	assign new_rec  = '{key: r_q.key, model: model_q, color: r_q.color, gender: r_q.gender,
		size: r_q.size, price: r_q.price};
	assign mid_c    = CW'(lo_q + ((hx_q - lo_q - CW'(1)) >> 1));
	assign out_free = !ov_q || rsp.ready;

	// Table and found-list port steering
	always_comb begin
		t_we    = 1'b0;
		t_re    = 1'b0;
		t_waddr = idx_q[AW-1:0];
		t_raddr = idx_q[AW-1:0];
		t_wdata = t_rd;
		f_we    = 1'b0;
		f_re    = 1'b0;
		f_waddr = k_q[AW-1:0];
		f_raddr = ei_q[AW-1:0];
		f_wdata = cand_q;
		case (cmd)
			CMD_ISCAN_RD: t_re = 1'b1;
			CMD_ISHIFT_RD: begin
				t_re    = 1'b1;
				t_raddr = AW'(idx_q - CW'(1));
			end
			CMD_ISHIFT_WR: t_we = 1'b1;
			CMD_IWRITE: begin
				t_we    = 1'b1;
				t_waddr = pos_q[AW-1:0];
				t_wdata = new_rec;
			end
			CMD_BIN_RD: begin
				t_re    = 1'b1;
				t_raddr = mid_c[AW-1:0];
			end
			CMD_RD_DN: begin
				t_re    = 1'b1;
				t_raddr = AW'(j_q - CW'(1));
			end
			CMD_RD_UP: begin
				t_re    = 1'b1;
				t_raddr = AW'(j_q + CW'(1));
			end
			CMD_FREAD: begin
				f_re    = 1'b1;
				f_raddr = AW'(k_q - CW'(1));
			end
			CMD_FPLACE: f_we = 1'b1;
			CMD_FSHIFT: begin
				f_we    = 1'b1;
				f_wdata = f_rd;
			end
			CMD_EMIT_RD: f_re = 1'b1;
			default: begin
			end
		endcase
	end

	sktrs_ram #(.W(REC_W), .D(TABLE_DEPTH)) u_tbl (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.re(t_re), .raddr(t_raddr), .rdata(t_rd)
	);

	sktrs_ram #(.W(REC_W), .D(TABLE_DEPTH)) u_found (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.re(f_re), .raddr(f_raddr), .rdata(f_rd)
	);

	always_comb begin
		flg.key_bad   = (r_q.key < KEY_MIN) || (r_q.key > KEY_MAX);
		flg.is_ins    = (r_q.func == FUNC_INSERT);
		flg.full      = (cnt_q == CW'(TABLE_DEPTH));
		flg.idx_end   = (idx_q == cnt_q);
		flg.pos_hit   = (idx_q == pos_q);
		flg.bin_empty = (lo_q >= hx_q);
		flg.t_eq      = (t_rd.key == r_q.key);
		flg.dn        = dn_q;
		flg.j_zero    = (j_q == '0);
		flg.j_last    = (CW'(j_q + CW'(1)) >= cnt_q);
		flg.skip      = r_q.filt && (cand_q.gender != r_q.gender);
		flg.k_zero    = (k_q == '0);
		flg.by_price  = r_q.by_price;
		flg.shift_ok  = r_q.desc ? (cand_q.price > f_rd.price) : (cand_q.price < f_rd.price);
		flg.nf_zero   = (nf_q == '0);
		flg.emit_last = (CW'(ei_q + CW'(1)) == nf_q);
		flg.out_free  = out_free;
	end

	// Control state: record count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (cmd == CMD_IWRITE) begin
				cnt_q <= CW'(cnt_q + CW'(1));
			end
			if (cmd == CMD_EMIT_PUSH || cmd == CMD_RESP_PUSH) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: r_q <= req;
			CMD_SET_BAD: stat_q <= ST_BAD_TYPE;
			CMD_SET_FULL: stat_q <= ST_FULL;
			CMD_SET_NOTFOUND: stat_q <= ST_NOT_FOUND;
			CMD_SET_NONE: stat_q <= ST_NONE_KEPT;
			CMD_INS_INIT: begin
				idx_q   <= '0;
				model_q <= 7'd1;
				pos_q   <= cnt_q;
				posf_q  <= 1'b0;
			end
			CMD_ISCAN_CHK: begin
				if (t_rd.key == r_q.key && t_rd.model >= model_q) begin
					model_q <= 7'(t_rd.model + 7'd1);
				end
				if (!posf_q && t_rd.key > r_q.key) begin
					pos_q  <= idx_q;
					posf_q <= 1'b1;
				end
				idx_q <= CW'(idx_q + CW'(1));
			end
			CMD_ISHIFT_WR: idx_q <= CW'(idx_q - CW'(1));
			CMD_IWRITE: stat_q <= ST_ADDED;
			CMD_SRCH_INIT: begin
				lo_q <= '0;
				hx_q <= cnt_q;
				nf_q <= '0;
			end
			CMD_BIN_RD: mid_q <= mid_c;
			CMD_BIN_CHK: begin
				if (t_rd.key == r_q.key) begin
					cand_q <= t_rd;
					dn_q   <= 1'b1;
					j_q    <= mid_q;
					k_q    <= nf_q;
				end else if (t_rd.key < r_q.key) begin
					lo_q <= CW'(mid_q + CW'(1));
				end else begin
					hx_q <= mid_q;
				end
			end
			CMD_TURN: begin
				dn_q <= 1'b0;
				j_q  <= mid_q;
			end
			CMD_RD_DN: j_q <= CW'(j_q - CW'(1));
			CMD_RD_UP: j_q <= CW'(j_q + CW'(1));
			CMD_TAKE: begin
				cand_q <= t_rd;
				k_q    <= nf_q;
			end
			CMD_FPLACE: nf_q <= CW'(nf_q + CW'(1));
			CMD_FSHIFT: k_q <= CW'(k_q - CW'(1));
			CMD_EMIT_INIT: ei_q <= '0;
			CMD_EMIT_PUSH: begin
				o_q     <= f_rd;
				ost_q   <= ST_RECORD;
				olast_q <= flg.emit_last;
				ei_q    <= CW'(ei_q + CW'(1));
			end
			CMD_RESP_PUSH: begin
				o_q     <= (stat_q == ST_ADDED) ? new_rec : rec_t'('0);
				ost_q   <= stat_q;
				olast_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid      = ov_q;
	assign rsp.status     = ost_q;
	assign rsp.rec_type   = o_q.key;
	assign rsp.rec_model  = o_q.model;
	assign rsp.rec_color  = o_q.color;
	assign rsp.rec_gender = o_q.gender;
	assign rsp.rec_size   = o_q.size;
	assign rsp.rec_price  = o_q.price;
	assign rsp.last       = olast_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH))
		else $error("record count above table depth");
	a_found_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_FPLACE) |-> (nf_q < cnt_q))
		else $error("found list grows past record count");
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_IWRITE) |=> (cnt_q == CW'($past(cnt_q) + CW'(1))))
		else $error("insert did not advance record count");
`endif
endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;
	import sktrs_pkg::*;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 10000000;

	logic clk;
	logic arst_n;

	sktrs_in_if  req_if();
	sktrs_out_if rsp_if();

	sorted_key_table_range_search #(.TABLE_DEPTH(DEPTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	typedef struct packed {
		status_t     status;
		logic [2:0]  rtype;
		logic [6:0]  model;
		logic [7:0]  color;
		logic [1:0]  gender;
		logic [2:0]  size;
		logic [23:0] price;
		logic        last;
	} result_t;

	// Shadow copy of the record table, kept in type order like the block's.
	rec_t    shadow_table[DEPTH];
	int      shadow_count;
	result_t pending_results[$];

	int      mismatches;
	int      results_seen;
	int      requests_sent;
	int      searches_sent;
	longint  cycle_count;
	bit      hold_off;
	int      hold_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Abort the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending",
				cycle_count, pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic result_t bare_result(status_t st);
		result_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic result_t record_result(status_t st, rec_t rc, logic lst);
		result_t r;
		r.status = st;
		r.rtype = rc.key;
		r.model = rc.model;
		r.color = rc.color;
		r.gender = rc.gender;
		r.size = rc.size;
		r.price = rc.price;
		r.last = lst;
		return r;
	endfunction

	// Append one expected result at the tail of the queue.
	function automatic void add_expected(result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Work out what the block returns for one request and update the shadow table.
	task automatic predict_request(req_t rq);
		rec_t nr;
		rec_t found[$];
		rec_t kept[$];
		rec_t k;
		int lo, hi, mid, pos, j;
		logic [6:0] model;
		if (rq.key < KEY_MIN || rq.key > KEY_MAX) begin
			add_expected(bare_result(ST_BAD_TYPE));
			return;
		end
		if (rq.func == FUNC_INSERT) begin
			if (shadow_count >= DEPTH) begin
				add_expected(bare_result(ST_FULL));
				return;
			end
			model = 7'd1;
			pos = shadow_count;
			for (int i = 0; i < shadow_count; i++)
				if (shadow_table[i].key == rq.key && shadow_table[i].model >= model)
					model = shadow_table[i].model + 7'd1;
			for (int i = 0; i < shadow_count; i++)
				if (shadow_table[i].key > rq.key) begin
					pos = i;
					break;
				end
			nr.key = rq.key;
			nr.model = model;
			nr.color = rq.color;
			nr.gender = rq.gender;
			nr.size = rq.size;
			nr.price = rq.price;
			for (int i = shadow_count; i > pos; i--)
				shadow_table[i] = shadow_table[i - 1];
			shadow_table[pos] = nr;
			shadow_count++;
			add_expected(record_result(ST_ADDED, nr, 1'b1));
			return;
		end
		// Binary search, then gather the hit, the run below it, the run above it.
		lo = 0;
		hi = shadow_count - 1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (shadow_table[mid].key == rq.key) begin
				found.insert(found.size(), shadow_table[mid]);
				for (j = mid - 1; j >= 0 && shadow_table[j].key == rq.key; j--)
					found.insert(found.size(), shadow_table[j]);
				for (j = mid + 1; j < shadow_count && shadow_table[j].key == rq.key; j++)
					found.insert(found.size(), shadow_table[j]);
				break;
			end else if (shadow_table[mid].key < rq.key)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		if (found.size() == 0) begin
			add_expected(bare_result(ST_NOT_FOUND));
			return;
		end
		// Stable insertion sort on price.
		if (rq.by_price)
			for (int i = 1; i < found.size(); i++) begin
				k = found[i];
				j = i - 1;
				while (j >= 0 && (rq.desc ? (k.price > found[j].price)
						: (k.price < found[j].price))) begin
					found[j + 1] = found[j];
					j--;
				end
				found[j + 1] = k;
			end
		foreach (found[i])
			if (!rq.filt || found[i].gender == rq.gender)
				kept.insert(kept.size(), found[i]);
		if (kept.size() == 0) begin
			add_expected(bare_result(ST_NONE_KEPT));
			return;
		end
		foreach (kept[i])
			add_expected(record_result(ST_RECORD, kept[i], i == kept.size() - 1));
	endtask

	// Drive one request, with a random gap first, and wait for it to be taken.
	task automatic send_request(req_t rq);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.func <= rq.func;
		req_if.type_code <= rq.key;
		req_if.color_code <= rq.color;
		req_if.gender_code <= rq.gender;
		req_if.size_code <= rq.size;
		req_if.price_cents <= rq.price;
		req_if.sort_by_price <= rq.by_price;
		req_if.descending <= rq.desc;
		req_if.filter_gender <= rq.filt;
		predict_request(rq);
		requests_sent++;
		if (rq.func != FUNC_INSERT)
			searches_sent++;
		do
			@(posedge clk);
		while (!req_if.ready);
	endtask

	task automatic finish_sending();
		req_if.valid <= 1'b0;
	endtask

	function automatic req_t random_request(logic fn, logic [2:0] key);
		req_t rq;
		rq.func = fn;
		rq.key = key;
		rq.color = 8'($urandom_range(0, 255));
		rq.gender = 2'($urandom_range(0, 3));
		rq.size = 3'($urandom_range(0, 7));
		// Few distinct prices now and then so ties show up in the sort.
		rq.price = ($urandom_range(0, 2) == 0) ? 24'($urandom_range(0, 3) * 1000)
			: 24'($urandom);
		rq.by_price = 1'($urandom_range(0, 1));
		rq.desc = 1'($urandom_range(0, 1));
		rq.filt = 1'($urandom_range(0, 1));
		return rq;
	endfunction

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Receiver: random stalls, plus a long hold-off when asked for.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (hold_off) begin
			rsp_if.ready <= 1'b0;
		end else begin
			case ($urandom_range(0, 19))
				0, 1, 2: rsp_if.ready <= 1'b0;
				default: rsp_if.ready <= 1'b1;
			endcase
		end
	end

	// Count the long hold-off in its own process.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_off <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			hold_off <= 1'b0;
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got.status = status_t'(rsp_if.status);
			got.rtype = rsp_if.rec_type;
			got.model = rsp_if.rec_model;
			got.color = rsp_if.rec_color;
			got.gender = rsp_if.rec_gender;
			got.size = rsp_if.rec_size;
			got.price = rsp_if.rec_price;
			got.last = rsp_if.last;
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch at result %0d: expected %p, got %p",
							results_seen, want, got);
				end
			end
		end
	end

	task automatic test_bad_and_empty();
		req_t rq;
		// Invalid keys on both functions, and a search of the empty table.
		rq = random_request(FUNC_INSERT, 3'd0);
		send_request(rq);
		rq = random_request(FUNC_INSERT, 3'd7);
		send_request(rq);
		rq = random_request(~FUNC_INSERT, 3'd0);
		send_request(rq);
		rq = random_request(~FUNC_INSERT, 3'd7);
		send_request(rq);
		rq = random_request(~FUNC_INSERT, 3'd3);
		send_request(rq);
	endtask

	task automatic test_directed_inserts();
		req_t rq;
		// Field extremes, out-of-order keys, and a run with tied prices.
		rq = random_request(FUNC_INSERT, 3'd6);
		rq.color = 8'hFF; rq.gender = 2'd3; rq.size = 3'd7; rq.price = 24'hFFFFFF;
		send_request(rq);
		rq = random_request(FUNC_INSERT, 3'd1);
		rq.color = 8'h00; rq.gender = 2'd0; rq.size = 3'd0; rq.price = 24'd0;
		send_request(rq);
		for (int i = 0; i < 5; i++) begin
			rq = random_request(FUNC_INSERT, 3'd3);
			rq.price = (i % 2) ? 24'd500 : 24'(100 * i);
			rq.gender = i[1:0];
			send_request(rq);
		end
	endtask

	task automatic test_directed_searches();
		req_t rq;
		// Every sort and filter combination on the run of key 3.
		for (int m = 0; m < 8; m++) begin
			rq = random_request(~FUNC_INSERT, 3'd3);
			rq.by_price = m[0]; rq.desc = m[1]; rq.filt = m[2];
			rq.gender = 2'd1;
			send_request(rq);
		end
		// Filter that keeps nothing, and a key never inserted.
		rq = random_request(~FUNC_INSERT, 3'd1);
		rq.filt = 1'b1; rq.gender = 2'd2;
		send_request(rq);
		rq = random_request(~FUNC_INSERT, 3'd5);
		send_request(rq);
		rq = random_request(~FUNC_INSERT, 3'd6);
		send_request(rq);
	endtask

	task automatic test_random_mix(int n);
		req_t rq;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 24) == 0)
				rq = random_request(1'($urandom_range(0, 1)),
					($urandom_range(0, 1) ? 3'd0 : 3'd7));
			else
				rq = random_request((shadow_count < DEPTH) ? ($urandom_range(0, 2) == 0)
					: ($urandom_range(0, 4) != 0), 3'($urandom_range(1, 6)));
			send_request(rq);
		end
	endtask

	// Fill the table to the top, then push more inserts to hit the full case.
	task automatic test_fill_to_full();
		req_t rq;
		while (shadow_count < DEPTH) begin
			rq = random_request(FUNC_INSERT, 3'($urandom_range(1, 6)));
			send_request(rq);
		end
		for (int i = 0; i < 3; i++) begin
			rq = random_request(FUNC_INSERT, 3'($urandom_range(1, 6)));
			send_request(rq);
		end
	endtask

	// Hold the receiver off while searches pile up behind the output.
	task automatic test_back_pressure();
		req_t rq;
		hold_cycles = 3000;
		for (int i = 0; i < 6; i++) begin
			rq = random_request(~FUNC_INSERT, 3'($urandom_range(1, 6)));
			send_request(rq);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cycle_count = 0;
		mismatches = 0;
		results_seen = 0;
		requests_sent = 0;
		searches_sent = 0;
		shadow_count = 0;
		hold_off = 1'b0;
		hold_cycles = 0;
		req_if.valid = 1'b0;
		req_if.func = 1'b0;
		req_if.type_code = '0;
		req_if.color_code = '0;
		req_if.gender_code = '0;
		req_if.size_code = '0;
		req_if.price_cents = '0;
		req_if.sort_by_price = 1'b0;
		req_if.descending = 1'b0;
		req_if.filter_gender = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bad_and_empty();
		test_directed_inserts();
		test_directed_searches();
		test_random_mix(150);
		test_back_pressure();
		test_fill_to_full();
		test_random_mix(148);
		finish_sending();
		wait_drained();

		$display("Sent %0d requests (%0d searches), checked %0d results, table held %0d",
			requests_sent, searches_sent, results_seen, shadow_count);
		$display("Covered bad keys, empty and full table, sort and filter modes, long stall");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				pending_results.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
